/* design/itab_pkg.sv */
// ============================================================================
// itab_pkg: shared types and codes of the node table engine
// Operation codes, node kinds, directory entry layout and the control
// bundle handed to the shared compare unit.
// ============================================================================
package itab_pkg;

    // Operation codes
    localparam logic [2:0] OP_CREATE    = 3'd0;
    localparam logic [2:0] OP_DELETE    = 3'd1;
    localparam logic [2:0] OP_GET       = 3'd2;
    localparam logic [2:0] OP_ADD_ENT   = 3'd3;
    localparam logic [2:0] OP_RESET_ENT = 3'd4;

    // Node kinds
    localparam logic [1:0] KIND_FREE = 2'd0;
    localparam logic [1:0] KIND_FILE = 2'd1;
    localparam logic [1:0] KIND_DIR  = 2'd2;

    // Result status
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Directory entry: valid bit on top of a child slot number
    localparam int ENT_BITS  = 7;
    localparam int ENT_VALID = 6;

    // What the compare unit looks for in the word read back
    typedef enum logic [1:0] {
        MODE_FREE_SLOT = 2'd0,
        MODE_FREE_ENT  = 2'd1,
        MODE_CHILD_ENT = 2'd2
    } match_mode_t;

    typedef struct packed {
        match_mode_t mode;
        logic [5:0]  child;
    } match_ctl_t;

endpackage

/* design/itab_ram.sv */
// ============================================================================
// itab_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module itab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/itab_match.sv */
// ============================================================================
// itab_match: shared compare unit
// Tests one word read back from either table against the current search:
// a free slot, a free directory entry, or a valid entry naming a child.
// ============================================================================
module itab_match (
    input  itab_pkg::match_ctl_t             ctl,
    input  logic [1:0]                       kind_data,
    input  logic [itab_pkg::ENT_BITS-1:0]    ent_data,
    output logic                             hit
);

    // Compare the word against the search target
    always_comb
    begin
        case (ctl.mode)
            itab_pkg::MODE_FREE_SLOT: hit = (kind_data == itab_pkg::KIND_FREE);
            itab_pkg::MODE_FREE_ENT:  hit = !ent_data[itab_pkg::ENT_VALID];
            itab_pkg::MODE_CHILD_ENT: hit = ent_data[itab_pkg::ENT_VALID]
                                            && (ent_data[5:0] == ctl.child);
            default:                  hit = 1'b0;
        endcase
    end

endmodule

/* design/inode_table_engine.sv */
// ============================================================================
// inode_table_engine: node slot table with per-directory child entries
// Sequencer around two RAMs and one shared compare unit that walks slots
// or directory entries one word per cycle.
// ============================================================================
// From acceptance to result valid: a bad kind or an unknown op goes straight
// to the result; delete and get end once the node kind is read; add and reset
// entry read node and child kinds, then walk the entries unless refused;
// create walks the slots, then clears a new directory's entries. One item at a
// time: the next item is taken the cycle after the result is registered.
// After reset the kind table is cleared slot by slot, in_ready low.
module inode_table_engine #(
    parameter int NUM_SLOTS       = 64,
    parameter int ENTRIES_PER_DIR = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] op,
    input  logic [5:0] node,
    input  logic [5:0] child,
    input  logic [1:0] new_kind,
    input  logic       name_empty,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       status,
    output logic [5:0] slot_out,
    output logic [1:0] kind_out
);

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int EIDX_W = (ENTRIES_PER_DIR > 1) ? $clog2(ENTRIES_PER_DIR) : 1;
    localparam int CNT_W  = (IDX_W > EIDX_W) ? IDX_W : EIDX_W;
    localparam int DEPTH  = NUM_SLOTS * ENTRIES_PER_DIR;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] SLOT_LAST = CNT_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0] ENT_LAST  = CNT_W'(ENTRIES_PER_DIR - 1);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_NODE  = 7'b0000100,
        S_CHILD = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_CLR   = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    // Control registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;

    // Item and working registers
    logic [2:0]          op_reg;
    logic [5:0]          node_reg;
    logic [5:0]          child_reg;
    logic [1:0]          kind_reg;
    logic                empty_reg;
    logic [CNT_W-1:0]    chk_reg, chk_next;
    itab_pkg::match_mode_t mode_reg, mode_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic                node_dir_reg, node_dir_next;
    logic                res_status_reg, res_status_next;
    logic [5:0]          res_slot_reg, res_slot_next;
    logic [1:0]          res_kind_reg, res_kind_next;
    logic                status_reg;
    logic [5:0]          slot_out_reg;
    logic [1:0]          kind_out_reg;

    logic                in_fire;
    logic                out_load;

    // RAM ports
    logic                           k_we;
    logic [IDX_W-1:0]               k_waddr, k_raddr;
    logic [1:0]                     k_wdata, k_rdata;
    logic                           e_we;
    logic [ADDR_W-1:0]              e_waddr, e_raddr;
    logic [itab_pkg::ENT_BITS-1:0]  e_wdata, e_rdata;

    // Compare unit
    itab_pkg::match_ctl_t match_ctl;
    logic                 hit;

    logic             node_rng, child_rng;
    logic             kind_ok;
    logic [CNT_W-1:0] last;

    itab_ram #(
        .WIDTH (2),
        .DEPTH (NUM_SLOTS)
    ) u_kind_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    itab_ram #(
        .WIDTH (itab_pkg::ENT_BITS),
        .DEPTH (DEPTH)
    ) u_ent_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    assign match_ctl.mode  = mode_reg;
    assign match_ctl.child = child_reg;

    itab_match u_match (
        .ctl       (match_ctl),
        .kind_data (k_rdata),
        .ent_data  (e_rdata),
        .hit       (hit)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign kind_out  = kind_out_reg;

    assign node_rng  = (32'(node_reg) < NUM_SLOTS);
    assign child_rng = (32'(child_reg) < NUM_SLOTS);
    assign kind_ok   = (new_kind == itab_pkg::KIND_FILE) || (new_kind == itab_pkg::KIND_DIR);
    assign last      = (mode_reg == itab_pkg::MODE_FREE_SLOT) ? SLOT_LAST : ENT_LAST;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        chk_next        = chk_reg;
        mode_next       = mode_reg;
        base_next       = base_reg;
        node_dir_next   = node_dir_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_kind_next   = res_kind_reg;
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;

        k_we    = 1'b0;
        k_waddr = IDX_W'(chk_reg);
        k_wdata = itab_pkg::KIND_FREE;
        k_raddr = IDX_W'(node);
        e_we    = 1'b0;
        e_waddr = base_reg + ADDR_W'(chk_reg);
        e_wdata = '0;
        e_raddr = base_reg + ADDR_W'(cnt_reg);

        case (state_reg)
            // Clear the kind table one slot a cycle
            S_INIT:
            begin
                k_we    = 1'b1;
                k_waddr = IDX_W'(cnt_reg);
                k_wdata = itab_pkg::KIND_FREE;
                if (cnt_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Take an item; the node's kind is read on the way in
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_status_next = itab_pkg::STATUS_FAIL;
                    res_slot_next   = '0;
                    res_kind_next   = itab_pkg::KIND_FREE;
                    cnt_next        = '0;
                    pend_next       = 1'b0;
                    case (op)
                        itab_pkg::OP_CREATE:
                        begin
                            mode_next  = itab_pkg::MODE_FREE_SLOT;
                            state_next = kind_ok ? S_SCAN : S_RESP;
                        end
                        itab_pkg::OP_DELETE,
                        itab_pkg::OP_GET,
                        itab_pkg::OP_ADD_ENT,
                        itab_pkg::OP_RESET_ENT:
                        begin
                            state_next = S_NODE;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // Node kind is back; finish delete and get, read the child kind
            S_NODE:
            begin
                k_raddr       = IDX_W'(child_reg);
                node_dir_next = node_rng && (k_rdata == itab_pkg::KIND_DIR);
                base_next     = ADDR_W'(node_reg) * ADDR_W'(ENTRIES_PER_DIR);
                case (op_reg)
                    itab_pkg::OP_DELETE:
                    begin
                        if (node_rng && (k_rdata != itab_pkg::KIND_FREE))
                        begin
                            k_we            = 1'b1;
                            k_waddr         = IDX_W'(node_reg);
                            k_wdata         = itab_pkg::KIND_FREE;
                            res_status_next = itab_pkg::STATUS_OK;
                        end
                        state_next = S_RESP;
                    end
                    itab_pkg::OP_GET:
                    begin
                        if (node_rng && (k_rdata != itab_pkg::KIND_FREE))
                        begin
                            res_kind_next   = k_rdata;
                            res_status_next = itab_pkg::STATUS_OK;
                        end
                        state_next = S_RESP;
                    end
                    default:
                    begin
                        state_next = S_CHILD;
                    end
                endcase
            end

            // Child kind is back; start the entry walk if the op can proceed
            S_CHILD:
            begin
                mode_next = (op_reg == itab_pkg::OP_ADD_ENT) ? itab_pkg::MODE_FREE_ENT
                                                             : itab_pkg::MODE_CHILD_ENT;
                if (node_dir_reg && child_rng && (k_rdata != itab_pkg::KIND_FREE)
                    && ((op_reg == itab_pkg::OP_RESET_ENT) || !empty_reg))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            // Walk slots or entries: issue one read, check the previous one
            S_SCAN:
            begin
                k_raddr   = IDX_W'(cnt_reg);
                chk_next  = cnt_reg;
                pend_next = 1'b1;
                if (cnt_reg != last)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (hit)
                    begin
                        res_status_next = itab_pkg::STATUS_OK;
                        case (mode_reg)
                            itab_pkg::MODE_FREE_SLOT:
                            begin
                                k_we          = 1'b1;
                                k_waddr       = IDX_W'(chk_reg);
                                k_wdata       = kind_reg;
                                res_slot_next = 6'(chk_reg);
                                base_next     = ADDR_W'(chk_reg) * ADDR_W'(ENTRIES_PER_DIR);
                                cnt_next      = '0;
                                state_next    = (kind_reg == itab_pkg::KIND_DIR) ? S_CLR
                                                                                 : S_RESP;
                            end
                            itab_pkg::MODE_FREE_ENT:
                            begin
                                e_we       = 1'b1;
                                e_wdata    = {1'b1, child_reg};
                                state_next = S_RESP;
                            end
                            default:
                            begin
                                e_we       = 1'b1;
                                e_wdata    = '0;
                                state_next = S_RESP;
                            end
                        endcase
                    end
                    else if (chk_reg == last)
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            // Clear the entries of a new directory
            S_CLR:
            begin
                e_we    = 1'b1;
                e_waddr = base_reg + ADDR_W'(cnt_reg);
                e_wdata = '0;
                if (cnt_reg == ENT_LAST)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Move the result into the output register once it is free
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
                cnt_next   = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item, working and result registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= op;
            node_reg  <= node;
            child_reg <= child;
            kind_reg  <= new_kind;
            empty_reg <= name_empty;
        end
        chk_reg        <= chk_next;
        mode_reg       <= mode_next;
        base_reg       <= base_next;
        node_dir_reg   <= node_dir_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_kind_reg   <= res_kind_next;
        if (out_load)
        begin
            status_reg   <= res_status_reg;
            slot_out_reg <= res_slot_reg;
            kind_out_reg <= res_kind_reg;
        end
    end

endmodule

/* design/itab_checker.sv */
// ============================================================================
// itab_checker: port-level checks of the node table engine
// Watches the item handshakes and the result fields over time.
// ============================================================================
module itab_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [2:0] op,
    input logic [5:0] node,
    input logic [5:0] child,
    input logic [1:0] new_kind,
    input logic       name_empty,
    input logic       out_valid,
    input logic       out_ready,
    input logic       status,
    input logic [5:0] slot_out,
    input logic [1:0] kind_out
);

    // A stalled result holds its place and payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
                                    && $stable(slot_out) && $stable(kind_out))
        else $error("stalled result changed");

    // A failed item reports no slot and no kind
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == itab_pkg::STATUS_FAIL) |->
            (slot_out == '0) && (kind_out == itab_pkg::KIND_FREE))
        else $error("failure result carries data");

    // No result reports a kind code outside free, file and directory
    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind_out == itab_pkg::KIND_FREE) || (kind_out == itab_pkg::KIND_FILE)
                      || (kind_out == itab_pkg::KIND_DIR))
        else $error("bad kind code on result");

    // One item at a time: no acceptance in the cycle after one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted back to back");

endmodule

bind inode_table_engine itab_checker u_itab_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for inode_table_engine
// Feeds create, delete, get and directory entry operations through the input
// channel, mirrors the slot table and directory entries to predict each
// result, and checks every result field against that prediction. Both
// channels stall at random, except for one stretch that runs at full rate.
// ============================================================================
module tb;

    localparam int N_SLOTS     = 64;
    localparam int N_ENT       = 16;
    localparam int N_ITEMS     = 1550;
    localparam int IDLE_PCT    = 15;
    localparam int STALL_LIMIT = 2000;
    localparam int END_WAIT    = 120;
    localparam int STEADY_LO   = 500;
    localparam int STEADY_HI   = 800;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] node;
        logic [5:0] child;
        logic [1:0] new_kind;
        logic       name_empty;
    } fs_req_t;

    typedef struct packed {
        logic       status;
        logic [5:0] slot;
        logic [1:0] kind;
    } fs_res_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] op = '0;
    logic [5:0] node = '0;
    logic [5:0] child = '0;
    logic [1:0] new_kind = '0;
    logic       name_empty = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       status;
    logic [5:0] slot_out;
    logic [1:0] kind_out;

    // Items waiting to be driven, and results owed by the block
    fs_req_t op_queue[$];
    fs_res_t pending_results[$];

    // Predicted state of the block
    logic [1:0]                    tbl_kind [N_SLOTS];
    logic [itab_pkg::ENT_BITS-1:0] tbl_ent  [N_SLOTS * N_ENT];

    // Slot kinds as the generator expects them when each item is applied
    logic [1:0] gen_kind [N_SLOTS];

    int n_taken = 0;
    int errors = 0;
    int stall_cycles = 0;
    logic steady;

    inode_table_engine #(
        .NUM_SLOTS       (N_SLOTS),
        .ENTRIES_PER_DIR (N_ENT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .node       (node),
        .child      (child),
        .new_kind   (new_kind),
        .name_empty (name_empty),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot_out   (slot_out),
        .kind_out   (kind_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    assign steady = (n_taken >= STEADY_LO) && (n_taken < STEADY_HI);

    function automatic bit is_used(logic [5:0] s);
        return int'(s) < N_SLOTS && tbl_kind[s] != itab_pkg::KIND_FREE;
    endfunction

    function automatic bit is_dir(logic [5:0] s);
        return int'(s) < N_SLOTS && tbl_kind[s] == itab_pkg::KIND_DIR;
    endfunction

    // Apply one operation to the predicted table and return its result
    function automatic fs_res_t table_apply(fs_req_t q);
        fs_res_t r;
        int base;
        bit done;
        r.status = itab_pkg::STATUS_FAIL;
        r.slot = '0;
        r.kind = itab_pkg::KIND_FREE;
        done = 1'b0;
        base = int'(q.node) * N_ENT;
        case (q.op)
            itab_pkg::OP_CREATE:
            begin
                if (q.new_kind == itab_pkg::KIND_FILE || q.new_kind == itab_pkg::KIND_DIR)
                begin
                    for (int i = 0; i < N_SLOTS; i++)
                    begin
                        if (!done && tbl_kind[i] == itab_pkg::KIND_FREE)
                        begin
                            tbl_kind[i] = q.new_kind;
                            if (q.new_kind == itab_pkg::KIND_DIR)
                                for (int e = 0; e < N_ENT; e++)
                                    tbl_ent[i * N_ENT + e] = '0;
                            r.status = itab_pkg::STATUS_OK;
                            r.slot = 6'(i);
                            done = 1'b1;
                        end
                    end
                end
            end
            itab_pkg::OP_DELETE:
            begin
                if (is_used(q.node))
                begin
                    tbl_kind[q.node] = itab_pkg::KIND_FREE;
                    r.status = itab_pkg::STATUS_OK;
                end
            end
            itab_pkg::OP_GET:
            begin
                if (is_used(q.node))
                begin
                    r.kind = tbl_kind[q.node];
                    r.status = itab_pkg::STATUS_OK;
                end
            end
            itab_pkg::OP_ADD_ENT:
            begin
                // first free entry takes the child
                if (is_dir(q.node) && is_used(q.child) && !q.name_empty)
                begin
                    for (int e = 0; e < N_ENT; e++)
                    begin
                        if (!done && !tbl_ent[base + e][itab_pkg::ENT_VALID])
                        begin
                            tbl_ent[base + e] = {1'b1, q.child};
                            r.status = itab_pkg::STATUS_OK;
                            done = 1'b1;
                        end
                    end
                end
            end
            itab_pkg::OP_RESET_ENT:
            begin
                // first valid entry naming the child is dropped
                if (is_dir(q.node) && is_used(q.child))
                begin
                    for (int e = 0; e < N_ENT; e++)
                    begin
                        if (!done && tbl_ent[base + e][itab_pkg::ENT_VALID]
                            && tbl_ent[base + e][5:0] == q.child)
                        begin
                            tbl_ent[base + e] = '0;
                            r.status = itab_pkg::STATUS_OK;
                            done = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Queue one item and track slot use so later items can aim at live slots
    task automatic push_item(logic [2:0] o, logic [5:0] n, logic [5:0] c,
                             logic [1:0] k, logic e);
        fs_req_t q;
        bit placed;
        q = {o, n, c, k, e};
        placed = 1'b0;
        op_queue.push_back(q);
        if (o == itab_pkg::OP_CREATE
            && (k == itab_pkg::KIND_FILE || k == itab_pkg::KIND_DIR))
        begin
            foreach (gen_kind[i])
            begin
                if (!placed && gen_kind[i] == itab_pkg::KIND_FREE)
                begin
                    gen_kind[i] = k;
                    placed = 1'b1;
                end
            end
        end
        else if (o == itab_pkg::OP_DELETE && int'(n) < N_SLOTS)
            gen_kind[n] = itab_pkg::KIND_FREE;
    endtask

    // Pick a live slot, or a directory; any slot when none exists
    function automatic logic [5:0] pick_slot(bit dir_only);
        int cand[$];
        foreach (gen_kind[i])
            if (dir_only ? gen_kind[i] == itab_pkg::KIND_DIR
                         : gen_kind[i] != itab_pkg::KIND_FREE)
                cand.push_back(i);
        if (cand.size() == 0)
            return 6'($urandom);
        return 6'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    // Create until the table is full, then overflow it
    task automatic fill_burst();
        int n_free;
        n_free = 0;
        foreach (gen_kind[i])
            if (gen_kind[i] == itab_pkg::KIND_FREE)
                n_free++;
        repeat (n_free + 2)
            push_item(itab_pkg::OP_CREATE, 6'($urandom), 6'($urandom),
                      $urandom_range(0, 1) ? itab_pkg::KIND_DIR : itab_pkg::KIND_FILE,
                      1'($urandom));
    endtask

    // Overfill one directory, then try to remove some of its children
    task automatic dir_burst();
        logic [5:0] d;
        d = pick_slot(1'b1);
        repeat (N_ENT + 2)
            push_item(itab_pkg::OP_ADD_ENT, d, pick_slot(1'b0), itab_pkg::KIND_FILE, 1'b0);
        repeat (6)
            push_item(itab_pkg::OP_RESET_ENT, d, pick_slot(1'b0), itab_pkg::KIND_FILE, 1'b0);
    endtask

    // One random item: mostly aimed at live slots, some pure noise
    task automatic add_random_item(bit drain);
        int pick;
        int c_end;
        int d_end;
        logic [2:0] o;
        logic [5:0] n;
        logic [5:0] c;
        logic [1:0] k;
        logic e;
        pick = $urandom_range(0, 99);
        c_end = drain ? 18 : 34;
        d_end = drain ? 46 : 44;
        o = 3'($urandom);
        n = 6'($urandom);
        c = 6'($urandom);
        k = 2'($urandom);
        e = 1'($urandom);
        if (pick >= 10)
        begin
            e = ($urandom_range(0, 9) == 0);
            if (pick < c_end)
            begin
                o = itab_pkg::OP_CREATE;
                if ($urandom_range(0, 19) != 0)
                    k = $urandom_range(0, 1) ? itab_pkg::KIND_DIR : itab_pkg::KIND_FILE;
            end
            else if (pick < d_end)
            begin
                o = itab_pkg::OP_DELETE;
                if ($urandom_range(0, 4) != 0)
                    n = pick_slot(1'b0);
            end
            else if (pick < 54)
            begin
                o = itab_pkg::OP_GET;
                if ($urandom_range(0, 4) != 0)
                    n = pick_slot(1'b0);
            end
            else
            begin
                o = (pick < 80) ? itab_pkg::OP_ADD_ENT : itab_pkg::OP_RESET_ENT;
                if ($urandom_range(0, 6) != 0)
                    n = pick_slot(1'b1);
                if ($urandom_range(0, 6) != 0)
                    c = pick_slot(1'b0);
            end
        end
        push_item(o, n, c, k, e);
    endtask

    // Build the stimulus, release reset, and wait for the last result
    initial
    begin
        int roll;
        foreach (tbl_kind[i])
        begin
            tbl_kind[i] = itab_pkg::KIND_FREE;
            gen_kind[i] = itab_pkg::KIND_FREE;
        end
        foreach (tbl_ent[i])
            tbl_ent[i] = '0;

        // free slots, bad kinds, first file and directory
        push_item(itab_pkg::OP_GET, 6'd0, 6'd0, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_DELETE, 6'd0, 6'd0, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_CREATE, 6'd0, 6'd0, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_CREATE, 6'd63, 6'd63, 2'b11, 1'b1);
        push_item(itab_pkg::OP_CREATE, 6'd0, 6'd0, itab_pkg::KIND_FILE, 1'b0);
        push_item(itab_pkg::OP_CREATE, 6'd0, 6'd0, itab_pkg::KIND_DIR, 1'b0);
        push_item(itab_pkg::OP_GET, 6'd0, 6'd0, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_GET, 6'd1, 6'd0, itab_pkg::KIND_FREE, 1'b0);
        // entry ops: on a file, free child, empty name, then good ones
        push_item(itab_pkg::OP_ADD_ENT, 6'd0, 6'd1, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_ADD_ENT, 6'd1, 6'd63, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_ADD_ENT, 6'd1, 6'd0, itab_pkg::KIND_FREE, 1'b1);
        push_item(itab_pkg::OP_ADD_ENT, 6'd1, 6'd0, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_ADD_ENT, 6'd1, 6'd1, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_RESET_ENT, 6'd1, 6'd63, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_RESET_ENT, 6'd0, 6'd1, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_RESET_ENT, 6'd1, 6'd1, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_RESET_ENT, 6'd1, 6'd1, itab_pkg::KIND_FREE, 1'b0);
        // unused op codes with every other field at its top
        for (int u = int'(itab_pkg::OP_RESET_ENT) + 1; u < 8; u++)
            push_item(3'(u), 6'd63, 6'd63, 2'b11, 1'b1);
        // deleted directory keeps stale entries until it is created again
        push_item(itab_pkg::OP_DELETE, 6'd1, 6'd0, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_GET, 6'd1, 6'd0, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_CREATE, 6'd0, 6'd0, itab_pkg::KIND_DIR, 1'b0);
        push_item(itab_pkg::OP_RESET_ENT, 6'd1, 6'd0, itab_pkg::KIND_FREE, 1'b0);
        push_item(itab_pkg::OP_DELETE, 6'd63, 6'd0, itab_pkg::KIND_FREE, 1'b0);

        // full table and full directory early, then random mix
        fill_burst();
        dir_burst();
        while (op_queue.size() < N_ITEMS)
        begin
            roll = $urandom_range(0, 399);
            if (roll == 0)
                fill_burst();
            else if (roll == 1)
                dir_burst();
            else
                add_random_item(((op_queue.size() / 200) % 2) == 1);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Driver: predict on acceptance, then present the next item or idle
    always @(posedge clk)
    begin : drive
        fs_req_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_results.push_back(
                    table_apply({op, node, child, new_kind, name_empty}));
                n_taken <= n_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (op_queue.size() != 0
                    && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = op_queue.pop_front();
                    in_valid <= 1'b1;
                    op <= nxt.op;
                    node <= nxt.node;
                    child <= nxt.child;
                    new_kind <= nxt.new_kind;
                    name_empty <= nxt.name_empty;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result against the oldest prediction
    always @(posedge clk)
    begin : watch
        fs_res_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d slot %0d kind %0d",
                             $time, status, slot_out, kind_out);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, status);
                        errors++;
                    end
                    if (slot_out !== want.slot)
                    begin
                        $display("%0t: slot_out expected %0d, got %0d",
                                 $time, want.slot, slot_out);
                        errors++;
                    end
                    if (kind_out !== want.kind)
                    begin
                        $display("%0t: kind_out expected %0d, got %0d",
                                 $time, want.kind, kind_out);
                        errors++;
                    end
                end
            end
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule

/* filelist.f */
design/itab_pkg.sv
design/itab_ram.sv
design/itab_match.sv
design/inode_table_engine.sv
design/itab_checker.sv
bench/tb.sv
